// ===== design/pps_pkg.sv =====
package pps_pkg;

    localparam int POS_W  = 10;
    localparam int TOL_W  = 10;
    localparam int TICK_W = 8;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [TOL_W-1:0]  TOLERANCE_RESET = TOL_W'(20);
    localparam logic [TICK_W-1:0] DWELL_RESET     = TICK_W'(8);
    localparam logic [TICK_W-1:0] HOLD_RESET      = TICK_W'(4);

    typedef enum logic [1:0] {
        REG_TOLERANCE = 2'd0,
        REG_DWELL     = 2'd1,
        REG_HOLD      = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_RAISE      = 4'd1,
        PH_MOVE_X     = 4'd2,
        PH_MOVE_Y     = 4'd3,
        PH_LOWER      = 4'd4,
        PH_DWELL_PRE  = 4'd5,
        PH_HOLD       = 4'd6,
        PH_DWELL_POST = 4'd7,
        PH_RAISE_END  = 4'd8
    } phase_t;

    typedef struct packed {
        logic [TOL_W-1:0]  tolerance;
        logic [TICK_W-1:0] dwell_ticks;
        logic [TICK_W-1:0] suction_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic             start_req;
        logic [POS_W-1:0] target_x;
        logic [POS_W-1:0] target_y;
        logic             pick;
        logic [POS_W-1:0] x_position;
        logic [POS_W-1:0] y_position;
        logic             z_top_switch;
        logic             z_bottom_switch;
        logic             emergency_stop;
    } item_t;

    typedef struct packed {
        logic x_advance;
        logic x_retract;
        logic y_advance;
        logic y_retract;
        logic z_raise;
        logic z_lower;
        logic suction;
        logic busy_res;
        logic done_res;
        logic aborted;
    } result_t;

endpackage

// ===== design/pps_apb_regs.sv =====
module pps_apb_regs
    import pps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [TOL_W-1:0]  tolerance_reg;
    logic [TICK_W-1:0] dwell_reg;
    logic [TICK_W-1:0] hold_reg;
    logic              wr_en;
    reg_index_t        index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOLERANCE_RESET;
            dwell_reg     <= DWELL_RESET;
            hold_reg      <= HOLD_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_TOLERANCE: tolerance_reg <= pwdata[TOL_W-1:0];
                REG_DWELL:     dwell_reg     <= pwdata[TICK_W-1:0];
                REG_HOLD:      hold_reg      <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_TOLERANCE: prdata = DATA_W'(tolerance_reg);
            REG_DWELL:     prdata = DATA_W'(dwell_reg);
            REG_HOLD:      prdata = DATA_W'(hold_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.tolerance          = tolerance_reg;
    assign cfg.dwell_ticks        = dwell_reg;
    assign cfg.suction_hold_ticks = hold_reg;

endmodule

// ===== design/pps_core.sv =====
module pps_core
    import pps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] wait_count_reg, wait_count_next;
    logic [POS_W-1:0]  held_x_reg, held_x_next;
    logic [POS_W-1:0]  held_y_reg, held_y_next;
    logic              held_pick_reg, held_pick_next;
    logic              suction_on_reg, suction_on_next;

    logic [POS_W-1:0]  axis_pos;
    logic [POS_W-1:0]  axis_target;
    logic [POS_W:0]    pos_plus_tol;
    logic [POS_W:0]    target_plus_tol;
    logic              axis_fwd;
    logic              axis_back;
    logic [TICK_W-1:0] dwell_min1;
    logic [TICK_W-1:0] hold_min1;
    logic              wait_last;

    // One deadband comparator, shared by the two axis phases.
    assign axis_pos        = (phase_reg == PH_MOVE_Y) ? item.y_position : item.x_position;
    assign axis_target     = (phase_reg == PH_MOVE_Y) ? held_y_reg : held_x_reg;
    assign pos_plus_tol    = {1'b0, axis_pos} + (POS_W+1)'(cfg.tolerance);
    assign target_plus_tol = {1'b0, axis_target} + (POS_W+1)'(cfg.tolerance);
    assign axis_fwd        = pos_plus_tol < {1'b0, axis_target};
    assign axis_back       = {1'b0, axis_pos} > target_plus_tol;

    assign dwell_min1 = (cfg.dwell_ticks == '0) ? TICK_W'(1) : cfg.dwell_ticks;
    assign hold_min1  = (cfg.suction_hold_ticks == '0) ? TICK_W'(1) : cfg.suction_hold_ticks;
    assign wait_last  = wait_count_reg <= TICK_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            wait_count_reg <= '0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_pick_reg  <= 1'b0;
            suction_on_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            wait_count_reg <= wait_count_next;
            held_x_reg     <= held_x_next;
            held_y_reg     <= held_y_next;
            held_pick_reg  <= held_pick_next;
            suction_on_reg <= suction_on_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        held_pick_next  = held_pick_reg;
        suction_on_next = suction_on_reg;
        res             = '0;

        if (item.emergency_stop)
        begin
            res.aborted = (phase_reg != PH_IDLE);
            phase_next  = PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_RAISE:
                begin
                    if (item.z_top_switch)
                        phase_next = PH_MOVE_X;
                    else
                        res.z_raise = 1'b1;
                end
                PH_MOVE_X:
                begin
                    res.x_advance = axis_fwd;
                    res.x_retract = !axis_fwd && axis_back;
                    if (!axis_fwd && !axis_back)
                        phase_next = PH_MOVE_Y;
                end
                PH_MOVE_Y:
                begin
                    res.y_advance = axis_fwd;
                    res.y_retract = !axis_fwd && axis_back;
                    if (!axis_fwd && !axis_back)
                        phase_next = PH_LOWER;
                end
                PH_LOWER:
                begin
                    if (item.z_bottom_switch)
                    begin
                        wait_count_next = dwell_min1;
                        phase_next      = PH_DWELL_PRE;
                    end
                    else
                        res.z_lower = 1'b1;
                end
                PH_DWELL_PRE:
                begin
                    if (wait_last)
                    begin
                        suction_on_next = held_pick_reg;
                        wait_count_next = hold_min1;
                        phase_next      = PH_HOLD;
                    end
                    else
                        wait_count_next = wait_count_reg - TICK_W'(1);
                end
                PH_HOLD:
                begin
                    if (wait_last)
                    begin
                        wait_count_next = dwell_min1;
                        phase_next      = PH_DWELL_POST;
                    end
                    else
                        wait_count_next = wait_count_reg - TICK_W'(1);
                end
                PH_DWELL_POST:
                begin
                    if (wait_last)
                    begin
                        wait_count_next = '0;
                        phase_next      = PH_RAISE_END;
                    end
                    else
                        wait_count_next = wait_count_reg - TICK_W'(1);
                end
                PH_RAISE_END:
                begin
                    if (item.z_top_switch)
                    begin
                        phase_next   = PH_IDLE;
                        res.done_res = 1'b1;
                    end
                    else
                        res.z_raise = 1'b1;
                end
                default:
                begin
                    // Idle, and any code the sequencer never reaches.
                    phase_next = PH_IDLE;
                    if (item.start_req)
                    begin
                        held_x_next    = item.target_x;
                        held_y_next    = item.target_y;
                        held_pick_next = item.pick;
                        phase_next     = PH_RAISE;
                    end
                end
            endcase
        end

        res.suction  = suction_on_next;
        res.busy_res = (phase_next != PH_IDLE);
    end

endmodule

// ===== design/pick_place_axis_sequencer.sv =====
// Pick-and-place sequencer: each request is one control tick carrying the start command,
// targets, position readings, Z switches and emergency stop; it yields exactly one result
// with the drive, suction and status flags for that tick. A request passes through an input
// register, the sequencer logic and a result register, and a new request is taken in every
// cycle while the result side keeps up. The registers at byte addresses 0, 4 and 8 hold
// tolerance, dwell_ticks and suction_hold_ticks and should only be written while no
// request is in flight.
module pick_place_axis_sequencer
    import pps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg, item_valid_next;
    result_t result_reg;
    logic    result_valid_reg, result_valid_next;
    result_t step_res;
    logic    advance;
    logic    take;

    pps_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pps_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    // The held request moves into the result register whenever that register is free
    // or is being emptied in the same cycle.
    assign advance    = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    assign item_valid_next   = take || (item_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item;
        if (advance)
            result_reg <= step_res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_one_drive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot0({result.x_advance, result.x_retract, result.y_advance,
                                   result.y_retract, result.z_raise, result.z_lower}))
        else $error("more than one drive active in a result");

    a_idle_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.busy_res) |-> !(result.x_advance || result.x_retract ||
            result.y_advance || result.y_retract || result.z_raise || result.z_lower))
        else $error("drive active while sequencer reports idle");

    a_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.done_res || result.aborted)) |->
            (!result.busy_res && !(result.done_res && result.aborted)))
        else $error("completion or abort flagged while busy, or both at once");

    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |=> (item_valid_reg && $stable(item_reg)))
        else $error("held request lost while stalled");
`endif

endmodule

// ===== verif/tb.sv =====
module tb
    import pps_pkg::*;
();

    localparam int MAX_POS      = (1 << POS_W) - 1;
    localparam int ITEM_W       = $bits(item_t);
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    localparam int PHASES       = 4;

    typedef struct {
        item_t   req;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_stall;
    item_t             item         = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;
    logic              psel         = 1'b0;
    logic              penable      = 1'b0;
    logic              pwrite       = 1'b0;
    logic [ADDR_W-1:0] paddr        = '0;
    logic [DATA_W-1:0] pwdata       = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pick_place_axis_sequencer dut (.*);

    // Sequencer state as the checker sees it.
    logic [TOL_W-1:0]  seq_tol    = TOLERANCE_RESET;
    logic [TICK_W-1:0] seq_dwell  = DWELL_RESET;
    logic [TICK_W-1:0] seq_hold   = HOLD_RESET;
    phase_t            seq_phase  = PH_IDLE;
    logic [TICK_W-1:0] seq_wait   = '0;
    logic [POS_W-1:0]  held_x     = '0;
    logic [POS_W-1:0]  held_y     = '0;
    logic              held_pick  = 1'b0;
    logic              suction_on = 1'b0;

    result_t pending_drives [$];
    int      mismatches       = 0;
    int      results_seen     = 0;
    bit      hold_off_results = 1'b0;
    bit      sender_quiet     = 1'b0;

    string drive_field [9:0] = '{"x_advance", "x_retract", "y_advance", "y_retract",
                                 "z_raise", "z_lower", "suction", "busy_res",
                                 "done_res", "aborted"};

    int phase_tol   [PHASES] = '{0, 1023, 37, 20};
    int phase_dwell [PHASES] = '{1, 3, 255, 8};
    int phase_hold  [PHASES] = '{1, 255, 1, 4};
    int phase_items [PHASES] = '{120, 330, 450, 150};

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL pick_place_axis_sequencer");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
            $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Returns {advance, retract}; zero means the axis sits in the deadband.
    function automatic logic [1:0] axis_drive(logic [POS_W-1:0] pos, logic [POS_W-1:0] target);
        if (int'(pos) + int'(seq_tol) < int'(target))
            return 2'b10;
        if (int'(pos) > int'(target) + int'(seq_tol))
            return 2'b01;
        return 2'b00;
    endfunction

    function automatic logic [TICK_W-1:0] ticks_or_one(logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

    function automatic result_t sequencer_step(item_t req);
        result_t    r;
        logic [1:0] drive;
        r = '0;
        if (req.emergency_stop)
        begin
            r.aborted = (seq_phase != PH_IDLE);
            seq_phase = PH_IDLE;
        end
        else
        begin
            case (seq_phase)
                PH_IDLE:
                    if (req.start_req)
                    begin
                        held_x    = req.target_x;
                        held_y    = req.target_y;
                        held_pick = req.pick;
                        seq_phase = PH_RAISE;
                    end
                PH_RAISE:
                    if (req.z_top_switch)
                        seq_phase = PH_MOVE_X;
                    else
                        r.z_raise = 1'b1;
                PH_MOVE_X:
                begin
                    drive = axis_drive(req.x_position, held_x);
                    {r.x_advance, r.x_retract} = drive;
                    if (drive == 2'b00)
                        seq_phase = PH_MOVE_Y;
                end
                PH_MOVE_Y:
                begin
                    drive = axis_drive(req.y_position, held_y);
                    {r.y_advance, r.y_retract} = drive;
                    if (drive == 2'b00)
                        seq_phase = PH_LOWER;
                end
                PH_LOWER:
                    if (req.z_bottom_switch)
                    begin
                        seq_wait  = ticks_or_one(seq_dwell);
                        seq_phase = PH_DWELL_PRE;
                    end
                    else
                        r.z_lower = 1'b1;
                PH_DWELL_PRE:
                    if (seq_wait <= TICK_W'(1))
                    begin
                        suction_on = held_pick;
                        seq_wait   = ticks_or_one(seq_hold);
                        seq_phase  = PH_HOLD;
                    end
                    else
                        seq_wait = seq_wait - 1'b1;
                PH_HOLD:
                    if (seq_wait <= TICK_W'(1))
                    begin
                        seq_wait  = ticks_or_one(seq_dwell);
                        seq_phase = PH_DWELL_POST;
                    end
                    else
                        seq_wait = seq_wait - 1'b1;
                PH_DWELL_POST:
                    if (seq_wait <= TICK_W'(1))
                    begin
                        seq_wait  = '0;
                        seq_phase = PH_RAISE_END;
                    end
                    else
                        seq_wait = seq_wait - 1'b1;
                PH_RAISE_END:
                    if (req.z_top_switch)
                    begin
                        seq_phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                    else
                        r.z_raise = 1'b1;
                default:
                    seq_phase = PH_IDLE;
            endcase
        end
        r.suction  = suction_on;
        r.busy_res = (seq_phase != PH_IDLE);
        return r;
    endfunction

    // Positions inside, on the edges of and just outside the deadband, or anywhere in range.
    function automatic logic [POS_W-1:0] position_near(logic [POS_W-1:0] target);
        int lo;
        int hi;
        int p;
        lo = int'(target) - int'(seq_tol);
        hi = int'(target) + int'(seq_tol);
        if (lo < 0)
            lo = 0;
        if (hi > MAX_POS)
            hi = MAX_POS;
        case ($urandom_range(0, 5))
            0, 1:    p = $urandom_range(hi, lo);
            2:       p = lo;
            3:       p = hi;
            4:       p = (lo > 0) ? lo - 1 : ((hi < MAX_POS) ? hi + 1 : lo);
            default: p = $urandom_range(MAX_POS, 0);
        endcase
        return POS_W'(p);
    endfunction

    // Mostly requests that move the cycle along; a tenth are pure noise.
    function automatic item_t shaped_request();
        item_t             req;
        logic [ITEM_W-1:0] raw;
        raw = ITEM_W'({$urandom, $urandom});
        req = raw;
        if ($urandom_range(0, 9) == 0)
            return req;
        req.emergency_stop = ($urandom_range(0, 63) == 0);
        case (seq_phase)
            PH_IDLE:
            begin
                req.start_req = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 7))
                    0:       req.target_x = '0;
                    1:       req.target_x = '1;
                    2:       req.target_y = '0;
                    3:       req.target_y = '1;
                    default: ;
                endcase
            end
            PH_RAISE, PH_RAISE_END:
                req.z_top_switch = ($urandom_range(0, 2) == 0);
            PH_MOVE_X:
                req.x_position = position_near(held_x);
            PH_MOVE_Y:
                req.y_position = position_near(held_y);
            PH_LOWER:
                req.z_bottom_switch = ($urandom_range(0, 2) == 0);
            default: ;
        endcase
        return req;
    endfunction

    function automatic item_t request_of(int start, int tx, int ty, int pick, int xp, int yp,
                                         int ztop, int zbot, int estop);
        item_t req;
        req.start_req       = start[0];
        req.target_x        = POS_W'(tx);
        req.target_y        = POS_W'(ty);
        req.pick            = pick[0];
        req.x_position      = POS_W'(xp);
        req.y_position      = POS_W'(yp);
        req.z_top_switch    = ztop[0];
        req.z_bottom_switch = zbot[0];
        req.emergency_stop  = estop[0];
        return req;
    endfunction

    task automatic reg_write(input reg_index_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TOLERANCE: seq_tol   = value[TOL_W-1:0];
            REG_DWELL:     seq_dwell = value[TICK_W-1:0];
            REG_HOLD:      seq_hold  = value[TICK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic reg_read_check(input reg_index_t idx, input logic [DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(int'(idx) * 4);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== want)
            report_mismatch($sformatf("register %s reads %0h, want %0h",
                                      idx.name(), prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offers one request, then predicts its result once it has been taken.
    task automatic offer(input item_t req, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        if ($urandom_range(0, 31) == 0)
            sender_quiet = !sender_quiet;
        gap = (sender_quiet || hold_off_results) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        do @(posedge clk); while (item_stall !== 1'b0);
        predicted = sequencer_step(req);
        pending_drives.push_back(typed ? want : predicted);
    endtask

    task automatic wait_results_idle();
        item_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_drives(input result_t got);
        result_t want;
        if (pending_drives.size() == 0)
            report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        else
        begin
            want = pending_drives.pop_front();
            for (int i = $bits(result_t) - 1; i >= 0; i--)
                if (got[i] !== want[i])
                    report_mismatch($sformatf("result %0d: %s is %b, want %b",
                                              results_seen, drive_field[i], got[i], want[i]));
        end
        results_seen++;
    endtask

    initial
    begin : result_sink
        int gap;
        bit quiet;
        quiet = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 16);
            if (hold_off_results)
            begin
                // Long back-pressure so the block fills and stalls its input.
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off_results = 1'b0;
            end
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (result_valid !== 1'b1);
            check_drives(result);
        end
    end

    initial
    begin : stimulus
        dir_row_t directed [$];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        reg_read_check(REG_TOLERANCE, DATA_W'(TOLERANCE_RESET));
        reg_read_check(REG_DWELL, DATA_W'(DWELL_RESET));
        reg_read_check(REG_HOLD, DATA_W'(HOLD_RESET));

        // Zero timing registers must behave as a single tick.
        reg_write(REG_TOLERANCE, 20);
        reg_write(REG_DWELL, '0);
        reg_write(REG_HOLD, '0);

        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
        directed.push_back(dir_row_t'{request_of(1, 1023, 1023, 1, 1023, 1023, 1, 1, 1),
                                      1'b1, '0});
        directed.push_back(dir_row_t'{request_of(1, 1023, 0, 1, 0, 0, 1, 0, 0), 1'b1,
                                      result_t'{busy_res: 1'b1, default: 1'b0}});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 1, 1, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(1, 0, 0, 0, 1003, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 1023, 0, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 20, 0, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(1, 0, 1023, 0, 512, 512, 0, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 1023, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1,
                                      result_t'{suction: 1'b1, aborted: 1'b1, default: 1'b0}});
        directed.push_back(dir_row_t'{request_of(0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0});

        foreach (directed[i])
            offer(directed[i].req, directed[i].typed, directed[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_results_idle();
            reg_write(REG_TOLERANCE, phase_tol[p]);
            reg_write(REG_DWELL, phase_dwell[p]);
            reg_write(REG_HOLD, phase_hold[p]);
            if (p == 1)
                hold_off_results = 1'b1;
            for (int n = 0; n < phase_items[p]; n++)
            begin
                if (p == 2 && n == phase_items[p] / 2)
                    wait_results_idle();
                offer(shaped_request(), 1'b0, '0);
            end
        end

        wait_results_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_drives.size() == 0)
            $display("PASS pick_place_axis_sequencer");
        else
            $display("FAIL pick_place_axis_sequencer");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pps_pkg.sv
design/pps_apb_regs.sv
design/pps_core.sv
design/pick_place_axis_sequencer.sv
verif/tb.sv
